// ----- sv/adsr_pkg.sv -----
// adsr_pkg: widths, stage codes, register map and shared types of the adsr envelope block
// used by every module of the block and by its checker, depends on nothing
package adsr_pkg;

    // level format: unsigned fixed point, one integer bit
    localparam int FRAC_BITS   = 15;
    localparam int LEVEL_W     = FRAC_BITS + 1;
    localparam int OUT_LEVEL_W = 16;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // stage lengths
    localparam int MAX_STAGE_LEN = 2048;
    localparam int LEN_W         = $clog2(MAX_STAGE_LEN) + 1;
    localparam int COUNT_W       = 11;

    // config register widths
    localparam int ATTACK_W  = 10;
    localparam int DECAY_W   = 11;
    localparam int SUSTAIN_W = 7;
    localparam int RELEASE_W = 12;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;

    localparam logic [ATTACK_W-1:0]  ATTACK_RESET  = ATTACK_W'(64);
    localparam logic [DECAY_W-1:0]   DECAY_RESET   = DECAY_W'(128);
    localparam logic [SUSTAIN_W-1:0] SUSTAIN_RESET = SUSTAIN_W'(30);
    localparam logic [RELEASE_W-1:0] RELEASE_RESET = RELEASE_W'(256);
    localparam logic [SUSTAIN_W-1:0] SUSTAIN_MAX   = SUSTAIN_W'(100);

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_SUSTAIN = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    // sustain level = pct * ONE / 100 by reciprocal multiply
    localparam int SUS_SHIFT = 32;
    localparam longint SUS_RECIP = ((64'd1 << SUS_SHIFT) + 64'd99) / 64'd100;
    localparam int RECIP_W = $clog2(SUS_RECIP + 1);
    localparam int SUS_PROD_W = SUSTAIN_W + RECIP_W;

    // shared multiplier and serial divider
    localparam int MUL_B_W   = LEN_W;
    localparam int PROD_W    = LEVEL_W + MUL_B_W;
    localparam int DIV_CNT_W = $clog2(PROD_W);

    // stage codes
    localparam logic [2:0] STAGE_OFF     = 3'd0;
    localparam logic [2:0] STAGE_ATTACK  = 3'd1;
    localparam logic [2:0] STAGE_DECAY   = 3'd2;
    localparam logic [2:0] STAGE_SUSTAIN = 3'd3;
    localparam logic [2:0] STAGE_RELEASE = 3'd4;

    typedef struct packed {
        logic [LEN_W-1:0]   attack_len;
        logic [LEN_W-1:0]   decay_len;
        logic [LEN_W-1:0]   release_len;
        logic [LEVEL_W-1:0] sus_level;
    } adsr_cfg_t;

    typedef struct packed {
        logic take;
        logic edge_apply;
        logic load;
        logic step;
        logic commit;
    } adsr_cmd_t;

    typedef struct packed {
        logic out_free;
    } adsr_sts_t;

endpackage

// ----- sv/adsr_regs.sv -----
// adsr_regs: apb register file for stage lengths and sustain, with clamping and sustain scaling
// depends on adsr_pkg
module adsr_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [adsr_pkg::APB_AW-1:0]   paddr,
    input  logic [adsr_pkg::APB_DW-1:0]   pwdata,
    output logic [adsr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output adsr_pkg::adsr_cfg_t           cfg
);

    logic [adsr_pkg::ATTACK_W-1:0]   attack_reg;
    logic [adsr_pkg::DECAY_W-1:0]    decay_reg;
    logic [adsr_pkg::SUSTAIN_W-1:0]  sustain_reg;
    logic [adsr_pkg::RELEASE_W-1:0]  release_reg;
    logic [adsr_pkg::LEVEL_W-1:0]    sus_reg;
    logic [adsr_pkg::LEVEL_W-1:0]    sus_next;
    logic [adsr_pkg::SUSTAIN_W-1:0]  pct_clamped;
    logic [adsr_pkg::SUS_PROD_W-1:0] sus_prod;
    logic [1:0]                      reg_idx;
    logic                            wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= adsr_pkg::ATTACK_RESET;
            decay_reg   <= adsr_pkg::DECAY_RESET;
            sustain_reg <= adsr_pkg::SUSTAIN_RESET;
            release_reg <= adsr_pkg::RELEASE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                adsr_pkg::REG_ATTACK:  attack_reg  <= pwdata[adsr_pkg::ATTACK_W-1:0];
                adsr_pkg::REG_DECAY:   decay_reg   <= pwdata[adsr_pkg::DECAY_W-1:0];
                adsr_pkg::REG_SUSTAIN: sustain_reg <= pwdata[adsr_pkg::SUSTAIN_W-1:0];
                adsr_pkg::REG_RELEASE: release_reg <= pwdata[adsr_pkg::RELEASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            adsr_pkg::REG_ATTACK:  prdata = adsr_pkg::APB_DW'(attack_reg);
            adsr_pkg::REG_DECAY:   prdata = adsr_pkg::APB_DW'(decay_reg);
            adsr_pkg::REG_SUSTAIN: prdata = adsr_pkg::APB_DW'(sustain_reg);
            adsr_pkg::REG_RELEASE: prdata = adsr_pkg::APB_DW'(release_reg);
            default:               prdata = '0;
        endcase
    end

    // sustain scaling, registered; the user must change config only while idle, the block does not enforce it
    always_comb
    begin
        pct_clamped = (sustain_reg > adsr_pkg::SUSTAIN_MAX) ? adsr_pkg::SUSTAIN_MAX : sustain_reg;
        sus_prod    = adsr_pkg::SUS_PROD_W'(pct_clamped)
                    * adsr_pkg::SUS_PROD_W'(adsr_pkg::SUS_RECIP);
        sus_next    = adsr_pkg::LEVEL_W'(sus_prod >> (adsr_pkg::SUS_SHIFT - adsr_pkg::FRAC_BITS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sus_reg <= '0;
        else
            sus_reg <= sus_next;
    end

    // zero length acts as one, overlong acts as the maximum
    function automatic logic [adsr_pkg::LEN_W-1:0] clamp_len(
        input logic [adsr_pkg::RELEASE_W-1:0] v
    );
        logic [adsr_pkg::LEN_W-1:0] r;
        if (v == '0)
            r = adsr_pkg::LEN_W'(1);
        else if (32'(v) > adsr_pkg::MAX_STAGE_LEN)
            r = adsr_pkg::LEN_W'(adsr_pkg::MAX_STAGE_LEN);
        else
            r = adsr_pkg::LEN_W'(v);
        return r;
    endfunction

    always_comb
    begin
        cfg.attack_len  = clamp_len(adsr_pkg::RELEASE_W'(attack_reg));
        cfg.decay_len   = clamp_len(adsr_pkg::RELEASE_W'(decay_reg));
        cfg.release_len = clamp_len(release_reg);
        cfg.sus_level   = sus_reg;
    end

endmodule

// ----- sv/adsr_ctrl.sv -----
// adsr_ctrl: sequencer for one sample: edge, operand load, serial divide, commit
// depends on adsr_pkg
module adsr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  adsr_pkg::adsr_sts_t   sts,
    output adsr_pkg::adsr_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EDGE = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    logic [adsr_pkg::DIV_CNT_W-1:0]   step_reg;
    logic [adsr_pkg::DIV_CNT_W-1:0]   step_next;

    assign sample_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                cmd.edge_apply = 1'b1;
                state_next     = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == adsr_pkg::DIV_CNT_W'(adsr_pkg::PROD_W - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- sv/adsr_dpath.sv -----
// adsr_dpath: envelope state, shared multiplier, restoring serial divider and output register
// depends on adsr_pkg
module adsr_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  adsr_pkg::adsr_cmd_t               cmd,
    input  adsr_pkg::adsr_cfg_t               cfg,
    input  logic                              gate,
    output adsr_pkg::adsr_sts_t               sts,
    output logic                              env_valid,
    input  logic                              env_stall,
    output logic [adsr_pkg::OUT_LEVEL_W-1:0]  level,
    output logic [2:0]                        phase
);

    localparam int LW = adsr_pkg::LEVEL_W;
    localparam int NW = adsr_pkg::LEN_W;
    localparam int PW = adsr_pkg::PROD_W;
    localparam int CW = adsr_pkg::COUNT_W;

    logic                gate_reg;
    logic                gate_prev_reg;
    logic [2:0]          stage_reg;
    logic [CW-1:0]       count_reg;
    logic [LW-1:0]       prev_reg;
    logic [NW-1:0]       len_reg;
    logic [PW-1:0]       num_reg;
    logic [NW-1:0]       rem_reg;
    logic                out_valid_reg;
    logic [adsr_pkg::OUT_LEVEL_W-1:0] level_reg;
    logic [2:0]          phase_reg;

    // operand selection
    logic [NW-1:0]                 len_sel;
    logic [LW-1:0]                 mul_a;
    logic [adsr_pkg::MUL_B_W-1:0]  mul_b;
    logic [PW-1:0]                 product;
    logic [NW-1:0]                 count_ext;

    // divider step
    logic [NW:0]   div_shift;
    logic [NW:0]   div_trial;
    logic          div_bit;

    // commit
    logic [NW-1:0] count_inc;
    logic          stage_end;
    logic [LW-1:0] span;
    logic [LW-1:0] drop;
    logic [LW-1:0] v;
    logic [2:0]    stage_new;
    logic [CW-1:0] count_new;

    assign count_ext = NW'(count_reg);

    always_comb
    begin
        len_sel = NW'(1);
        mul_a   = '0;
        mul_b   = '0;
        case (stage_reg)
            adsr_pkg::STAGE_ATTACK:
            begin
                len_sel = cfg.attack_len;
                mul_a   = adsr_pkg::LEVEL_ONE;
                mul_b   = count_ext;
            end
            adsr_pkg::STAGE_DECAY:
            begin
                len_sel = cfg.decay_len;
                mul_a   = adsr_pkg::LEVEL_ONE - cfg.sus_level;
                mul_b   = count_ext;
            end
            adsr_pkg::STAGE_RELEASE:
            begin
                len_sel = cfg.release_len;
                mul_a   = prev_reg;
                mul_b   = (count_ext < cfg.release_len) ? (cfg.release_len - count_ext) : '0;
            end
            default: ;
        endcase
        product = PW'(mul_a) * PW'(mul_b);
    end

    always_comb
    begin
        div_shift = {rem_reg, num_reg[PW-1]};
        div_trial = div_shift - {1'b0, len_reg};
        div_bit   = (div_shift >= {1'b0, len_reg});
    end

    // result of the stage, quotient sits in num_reg after the divide
    always_comb
    begin
        count_inc = count_ext + 1'b1;
        stage_end = (count_inc >= len_reg);
        span      = adsr_pkg::LEVEL_ONE - cfg.sus_level;
        drop      = (num_reg > PW'(span)) ? span : num_reg[LW-1:0];
        v         = '0;
        stage_new = stage_reg;
        count_new = count_reg;
        case (stage_reg)
            adsr_pkg::STAGE_ATTACK:
            begin
                v = (num_reg > PW'(adsr_pkg::LEVEL_ONE)) ? adsr_pkg::LEVEL_ONE : num_reg[LW-1:0];
                if (stage_end)
                begin
                    stage_new = adsr_pkg::STAGE_DECAY;
                    count_new = '0;
                end
                else
                    count_new = count_inc[CW-1:0];
            end
            adsr_pkg::STAGE_DECAY:
            begin
                v = adsr_pkg::LEVEL_ONE - drop;
                if (stage_end)
                begin
                    stage_new = adsr_pkg::STAGE_SUSTAIN;
                    count_new = '0;
                end
                else
                    count_new = count_inc[CW-1:0];
            end
            adsr_pkg::STAGE_SUSTAIN:
                v = cfg.sus_level;
            adsr_pkg::STAGE_RELEASE:
            begin
                if (stage_end)
                begin
                    stage_new = adsr_pkg::STAGE_OFF;
                    count_new = '0;
                end
                else
                begin
                    v         = num_reg[LW-1:0];
                    count_new = count_inc[CW-1:0];
                end
            end
            default:
                stage_new = adsr_pkg::STAGE_OFF;
        endcase
    end

    // envelope state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_prev_reg <= 1'b0;
            stage_reg     <= adsr_pkg::STAGE_OFF;
            count_reg     <= '0;
            prev_reg      <= '0;
        end
        else if (cmd.edge_apply)
        begin
            gate_prev_reg <= gate_reg;
            if (gate_reg && !gate_prev_reg)
            begin
                stage_reg <= adsr_pkg::STAGE_ATTACK;
                count_reg <= '0;
                prev_reg  <= '0;
            end
            else if (!gate_reg && gate_prev_reg)
            begin
                stage_reg <= adsr_pkg::STAGE_RELEASE;
                count_reg <= '0;
            end
        end
        else if (cmd.commit)
        begin
            stage_reg <= stage_new;
            count_reg <= count_new;
            prev_reg  <= v;
        end
    end

    // operand and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
            gate_reg <= gate;
        if (cmd.load)
        begin
            len_reg <= len_sel;
            num_reg <= product;
            rem_reg <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg <= div_bit ? div_trial[NW-1:0] : div_shift[NW-1:0];
            num_reg <= {num_reg[PW-2:0], div_bit};
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (!env_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            level_reg <= v[adsr_pkg::OUT_LEVEL_W-1:0];
            phase_reg <= stage_new;
        end
    end

    assign sts.out_free = !out_valid_reg || !env_stall;
    assign env_valid    = out_valid_reg;
    assign level        = level_reg;
    assign phase        = phase_reg;

endmodule

// ----- sv/adsr_envelope_generator_top.sv -----
// adsr_envelope_generator_top: gated linear adsr envelope, one gate beat in, one level beat out
// depends on adsr_pkg, adsr_regs, adsr_ctrl and adsr_dpath
//
//  channel   direction  handshake                    payload
//  sample    in         sample_valid / sample_stall  gate
//  env       out        env_valid / env_stall        level, phase
//  config    in         apb write/read               paddr, pwdata, prdata
//
// each sample beat runs through these steps from accept to result: take the beat,
// apply the gate edge, load the multiplier product, 28 steps of the restoring
// divider (one quotient bit per cycle), commit state and load the output register
// the serial divider is the longest part; sustain and off samples run the same sequence
// rst_n clears the sequencer, envelope state (off, zero level) and the registers to defaults
// a stalled result sits in the output register; the next sample beat is still accepted
// and worked on, and only its commit waits until the output register frees up
module adsr_envelope_generator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample channel
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic                                gate,
    // envelope channel
    output logic                                env_valid,
    input  logic                                env_stall,
    output logic [adsr_pkg::OUT_LEVEL_W-1:0]    level,
    output logic [2:0]                          phase,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [adsr_pkg::APB_AW-1:0]         paddr,
    input  logic [adsr_pkg::APB_DW-1:0]         pwdata,
    output logic [adsr_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    // clamped lengths and scaled sustain level
    adsr_pkg::adsr_cfg_t cfg;
    // sequencer commands and datapath status
    adsr_pkg::adsr_cmd_t cmd;
    adsr_pkg::adsr_sts_t sts;

    adsr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // one sample at a time: stall is raised from the accept until the commit
    adsr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    // stage math: value = a * b / len, saturated in attack and decay
    adsr_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg),
        .gate      (gate),
        .sts       (sts),
        .env_valid (env_valid),
        .env_stall (env_stall),
        .level     (level),
        .phase     (phase)
    );

endmodule

// ----- sv/adsr_chk.sv -----
// adsr_chk: port-level checks of the adsr envelope block, bound to the top level
// depends on adsr_pkg and adsr_envelope_generator_top
module adsr_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                sample_valid,
    input logic                                sample_stall,
    input logic                                env_valid,
    input logic                                env_stall,
    input logic [adsr_pkg::OUT_LEVEL_W-1:0]    level,
    input logic [2:0]                          phase
);

    // a sample beat keeps the block busy on the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("sample accepted twice in a row");

    // level never goes above full scale
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        env_valid |-> level <= adsr_pkg::OUT_LEVEL_W'(adsr_pkg::LEVEL_ONE))
        else $error("level above full scale");

    // off stage reports zero level
    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        env_valid && phase == adsr_pkg::STAGE_OFF |-> level == '0)
        else $error("nonzero level in off stage");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        env_valid && env_stall |=> env_valid && $stable(level) && $stable(phase))
        else $error("stalled envelope beat changed");

endmodule

bind adsr_envelope_generator_top adsr_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .env_valid    (env_valid),
    .env_stall    (env_stall),
    .level        (level),
    .phase        (phase)
);

// ----- bench/adsr_envelope_generator_top_tb.sv -----
// adsr_envelope_generator_top_tb: self-checking bench for the gated adsr envelope block
// a directed table and random gate sequences, checked against a local envelope predictor
// depends on adsr_pkg and adsr_envelope_generator_top
`timescale 1ns / 1ps

module adsr_envelope_generator_top_tb;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int TOTAL_BEATS    = 1150;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int IDLE_PCT       = 33;
    localparam int PCT_FULL_SCALE = 100;

    // one beat on the envelope channel
    typedef struct packed {
        logic [adsr_pkg::OUT_LEVEL_W-1:0] level;
        logic [2:0]                       phase;
    } env_beat_t;

    typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

    // one row of the directed table: a register write or a gate beat
    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        logic        g;
        bit          typed;
        env_beat_t   known;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        sample_valid = 1'b0;
    logic        sample_stall;
    logic        gate = 1'b0;
    logic        env_valid;
    logic        env_stall = 1'b0;
    logic [adsr_pkg::OUT_LEVEL_W-1:0] level;
    logic [2:0]  phase;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [adsr_pkg::APB_AW-1:0] paddr = '0;
    logic [adsr_pkg::APB_DW-1:0] pwdata = '0;
    logic [adsr_pkg::APB_DW-1:0] prdata;
    logic        pready;

    // shadow of the register file, at reset values
    logic [adsr_pkg::ATTACK_W-1:0]  shadow_attack  = adsr_pkg::ATTACK_RESET;
    logic [adsr_pkg::DECAY_W-1:0]   shadow_decay   = adsr_pkg::DECAY_RESET;
    logic [adsr_pkg::SUSTAIN_W-1:0] shadow_sustain = adsr_pkg::SUSTAIN_RESET;
    logic [adsr_pkg::RELEASE_W-1:0] shadow_release = adsr_pkg::RELEASE_RESET;

    // predicted envelope state
    logic [2:0]                   env_stage = adsr_pkg::STAGE_OFF;
    logic [adsr_pkg::COUNT_W-1:0] env_count = '0;
    logic [adsr_pkg::LEVEL_W-1:0] env_prev  = '0;
    logic                         env_gate_prev = 1'b0;

    env_beat_t expected_env_q[$];
    stim_row_t directed_rows[$];

    int  mismatches  = 0;
    int  beats_sent  = 0;
    int  cycle_count = 0;
    bit  idle_on     = 1'b1;

    adsr_envelope_generator_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .gate         (gate),
        .env_valid    (env_valid),
        .env_stall    (env_stall),
        .level        (level),
        .phase        (phase),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 clk = ~clk;

    // a zero length acts as one, anything past the longest stage is clipped to it
    function automatic longint unsigned eff_len(input longint unsigned raw);
        if (raw == 0)
            return 1;
        if (raw > adsr_pkg::MAX_STAGE_LEN)
            return adsr_pkg::MAX_STAGE_LEN;
        return raw;
    endfunction

    // advance the envelope by one gate sample and return the level beat it produces
    function automatic env_beat_t advance_envelope(input logic g);
        longint unsigned one;
        longint unsigned pct;
        longint unsigned sus;
        longint unsigned v;
        longint unsigned len;
        longint unsigned drop;
        longint unsigned rem;
        longint unsigned cnt;
        env_beat_t       res;
        one = longint'(1) << adsr_pkg::FRAC_BITS;
        pct = (shadow_sustain > adsr_pkg::SUSTAIN_MAX) ? adsr_pkg::SUSTAIN_MAX : shadow_sustain;
        sus = pct * one / PCT_FULL_SCALE;
        v   = 0;
        // gate edge goes first: rising restarts attack from zero, falling starts release
        if (g && !env_gate_prev)
        begin
            env_stage = adsr_pkg::STAGE_ATTACK;
            env_count = '0;
            env_prev  = '0;
        end
        else if (!g && env_gate_prev)
        begin
            env_stage = adsr_pkg::STAGE_RELEASE;
            env_count = '0;
        end
        env_gate_prev = g;
        cnt = env_count;
        case (env_stage)
            adsr_pkg::STAGE_ATTACK:
            begin
                len = eff_len(shadow_attack);
                v = cnt * one / len;
                if (v > one)
                    v = one;
                cnt++;
                if (cnt >= len)
                begin
                    env_stage = adsr_pkg::STAGE_DECAY;
                    cnt = 0;
                end
            end
            adsr_pkg::STAGE_DECAY:
            begin
                len = eff_len(shadow_decay);
                drop = (one - sus) * cnt / len;
                if (drop > one - sus)
                    drop = one - sus;
                v = one - drop;
                cnt++;
                if (cnt >= len)
                begin
                    env_stage = adsr_pkg::STAGE_SUSTAIN;
                    cnt = 0;
                end
            end
            adsr_pkg::STAGE_SUSTAIN:
            begin
                v = sus;
            end
            adsr_pkg::STAGE_RELEASE:
            begin
                len = eff_len(shadow_release);
                rem = (cnt < len) ? len - cnt : 0;
                v = longint'(env_prev) * rem / len;
                cnt++;
                if (cnt >= len)
                begin
                    env_stage = adsr_pkg::STAGE_OFF;
                    cnt = 0;
                    v = 0;
                end
            end
            default:
            begin
                env_stage = adsr_pkg::STAGE_OFF;
                v = 0;
            end
        endcase
        env_count = cnt[adsr_pkg::COUNT_W-1:0];
        env_prev  = v[adsr_pkg::LEVEL_W-1:0];
        res.level = v[adsr_pkg::OUT_LEVEL_W-1:0];
        res.phase = env_stage;
        return res;
    endfunction

    function automatic void add_cfg(input logic [1:0] idx, input logic [31:0] val);
        stim_row_t row;
        row = '{kind: ROW_CFG, reg_idx: idx, value: val, g: 1'b0, typed: 1'b0, known: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_beat(input logic g);
        stim_row_t row;
        row = '{kind: ROW_BEAT, reg_idx: adsr_pkg::REG_ATTACK, value: '0, g: g, typed: 1'b0,
                known: '0};
        directed_rows.push_back(row);
    endfunction

    // beat whose result is plain from the stage rules
    function automatic void add_known(input logic g,
                                      input logic [adsr_pkg::OUT_LEVEL_W-1:0] lvl,
                                      input logic [2:0] ph);
        stim_row_t row;
        row = '{kind: ROW_BEAT, reg_idx: adsr_pkg::REG_ATTACK, value: '0, g: g, typed: 1'b1,
                known: '{level: lvl, phase: ph}};
        directed_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // send one gate beat: optional random gap, then hold until the block takes it
    task automatic send_sample(input logic g, input bit typed, input env_beat_t known);
        env_beat_t pred;
        @(negedge clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        gate         <= g;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        // accepted at this edge; the predictor runs even for typed rows to keep its state
        pred = advance_envelope(g);
        expected_env_q.push_back(typed ? known : pred);
        beats_sent++;
    endtask

    // apb write, only once every expected level beat has come back
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        sample_valid <= 1'b0;
        while (expected_env_q.size() != 0)
            @(negedge clk);
        // setup phase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        // access phase
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            adsr_pkg::REG_ATTACK:  shadow_attack  = val[adsr_pkg::ATTACK_W-1:0];
            adsr_pkg::REG_DECAY:   shadow_decay   = val[adsr_pkg::DECAY_W-1:0];
            adsr_pkg::REG_SUSTAIN: shadow_sustain = val[adsr_pkg::SUSTAIN_W-1:0];
            adsr_pkg::REG_RELEASE: shadow_release = val[adsr_pkg::RELEASE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // receiver back-pressure, changes only on the falling edge
    always @(negedge clk)
        env_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);

    // level beat checker: every beat taken is matched against the oldest expectation
    always @(posedge clk)
    begin : env_check
        env_beat_t exp_beat;
        if (rst_n && env_valid && !env_stall)
        begin
            if (expected_env_q.size() == 0)
            begin
                report_mismatch($sformatf("level beat with nothing expected: level %0d phase %0d",
                                          level, phase));
            end
            else
            begin
                exp_beat = expected_env_q.pop_front();
                if (level !== exp_beat.level)
                    report_mismatch($sformatf("level got %0d want %0d",
                                              level, exp_beat.level));
                if (phase !== exp_beat.phase)
                    report_mismatch($sformatf("phase got %0d want %0d",
                                              phase, exp_beat.phase));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned rand_phase;
        int unsigned span;
        int unsigned on_len;
        int unsigned off_len;
        int          drain;
        logic [31:0] cfg_a;
        logic [31:0] cfg_d;
        logic [31:0] cfg_s;
        logic [31:0] cfg_r;

        // defaults after reset: off, then a fresh attack from zero
        add_known(1'b0, '0, adsr_pkg::STAGE_OFF);
        add_known(1'b1, '0, adsr_pkg::STAGE_ATTACK);
        add_beat(1'b1);
        add_beat(1'b0);
        // zero lengths act as one sample, sustain above hundred acts as full scale
        add_cfg(adsr_pkg::REG_ATTACK, 0);
        add_cfg(adsr_pkg::REG_DECAY, 0);
        add_cfg(adsr_pkg::REG_SUSTAIN, 127);
        add_cfg(adsr_pkg::REG_RELEASE, 0);
        add_known(1'b1, '0, adsr_pkg::STAGE_DECAY);
        add_known(1'b1, adsr_pkg::LEVEL_ONE, adsr_pkg::STAGE_SUSTAIN);
        add_known(1'b1, adsr_pkg::LEVEL_ONE, adsr_pkg::STAGE_SUSTAIN);
        add_known(1'b0, '0, adsr_pkg::STAGE_OFF);
        // widest register values, release past the longest stage gets clipped
        add_cfg(adsr_pkg::REG_ATTACK, 1023);
        add_cfg(adsr_pkg::REG_DECAY, 2047);
        add_cfg(adsr_pkg::REG_SUSTAIN, 0);
        add_cfg(adsr_pkg::REG_RELEASE, 4095);
        add_known(1'b1, '0, adsr_pkg::STAGE_ATTACK);
        add_beat(1'b1);
        add_beat(1'b0);
        add_beat(1'b0);
        // shortest stages with zero sustain
        add_cfg(adsr_pkg::REG_ATTACK, 1);
        add_cfg(adsr_pkg::REG_DECAY, 2);
        add_known(1'b1, '0, adsr_pkg::STAGE_DECAY);
        add_known(1'b1, adsr_pkg::LEVEL_ONE, adsr_pkg::STAGE_DECAY);
        add_beat(1'b1);
        // each stage shortened below its running count
        add_cfg(adsr_pkg::REG_ATTACK, 8);
        add_cfg(adsr_pkg::REG_DECAY, 8);
        add_cfg(adsr_pkg::REG_SUSTAIN, 50);
        add_cfg(adsr_pkg::REG_RELEASE, 8);
        add_beat(1'b0);
        add_beat(1'b1);
        add_beat(1'b1);
        add_cfg(adsr_pkg::REG_ATTACK, 1);
        add_known(1'b1, adsr_pkg::LEVEL_ONE, adsr_pkg::STAGE_DECAY);
        add_beat(1'b1);
        add_beat(1'b1);
        add_cfg(adsr_pkg::REG_DECAY, 1);
        add_beat(1'b1);
        add_beat(1'b0);
        add_beat(1'b0);
        add_cfg(adsr_pkg::REG_RELEASE, 1);
        add_known(1'b0, '0, adsr_pkg::STAGE_OFF);

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed table walk
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            else
                send_sample(directed_rows[i].g, directed_rows[i].typed, directed_rows[i].known);
        end

        // random part: each phase picks a register setting, then plays notes or gate chatter
        rand_phase = 0;
        while (beats_sent < TOTAL_BEATS)
        begin
            // phases four to six run with no gaps and no stalls
            idle_on = !(rand_phase >= 4 && rand_phase <= 6);
            if ($urandom_range(7) == 0)
            begin
                // full register width, out of range values included
                cfg_a = $urandom_range(1023);
                cfg_d = $urandom_range(2047);
                cfg_s = $urandom_range(127);
                cfg_r = $urandom_range(4095);
            end
            else
            begin
                // short stages so whole notes run through to off
                cfg_a = $urandom_range(12);
                cfg_d = $urandom_range(12);
                cfg_s = $urandom_range(PCT_FULL_SCALE);
                cfg_r = $urandom_range(24);
            end
            write_reg(adsr_pkg::REG_ATTACK, cfg_a);
            write_reg(adsr_pkg::REG_DECAY, cfg_d);
            write_reg(adsr_pkg::REG_SUSTAIN, cfg_s);
            write_reg(adsr_pkg::REG_RELEASE, cfg_r);
            repeat ($urandom_range(2, 5))
            begin
                if (beats_sent < TOTAL_BEATS)
                begin
                    if ($urandom_range(99) < 15)
                    begin
                        // noise: random gate chatter
                        repeat ($urandom_range(1, 20))
                            send_sample(1'($urandom_range(1)), 1'b0, '0);
                    end
                    else
                    begin
                        // a held note and its release
                        span = 32'(eff_len(shadow_attack) + eff_len(shadow_decay) + 8);
                        if (span > 48)
                            span = 48;
                        on_len = $urandom_range(1, span);
                        repeat (on_len)
                            send_sample(1'b1, 1'b0, '0);
                        span = 32'(eff_len(shadow_release) + 6);
                        if (span > 48)
                            span = 48;
                        off_len = $urandom_range(1, span);
                        repeat (off_len)
                            send_sample(1'b0, 1'b0, '0);
                    end
                end
            end
            rand_phase++;
        end

        @(negedge clk);
        sample_valid <= 1'b0;

        // drain outstanding level beats, then let the pipeline settle
        drain = 0;
        while (expected_env_q.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        if (expected_env_q.size() != 0)
            report_mismatch($sformatf("%0d level beats never arrived", expected_env_q.size()));
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
